@@ hw/rtl/chm_pkg.sv @@
package chm_pkg;

  // Sizing of the map
  localparam int MaxBuckets = 256;
  localparam int PoolNodes  = 1024;
  localparam int DataBits   = 64;

  localparam int BktW  = $clog2(MaxBuckets);
  localparam int NodeW = $clog2(PoolNodes);
  localparam int LinkW = NodeW + 1;
  localparam int CntW  = NodeW + 1;

  localparam logic [LinkW-1:0] NoNode = LinkW'(PoolNodes);

  // Bucket count register
  localparam int BcW = 9;
  localparam logic [BcW-1:0] BcReset = BcW'(251);

  // Commands
  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_data;
    logic [10:0] entry_count;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0]          command;
    logic [31:0]         key;
    logic [DataBits-1:0] data;
    logic [BktW-1:0]     bucket;
    logic                reserved;
  } work_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD_RD,
    BK_HEAD,
    BK_WALK,
    BK_ALLOC,
    BK_INSERT
  } back_state_e;

endpackage

@@ hw/rtl/chm_front.sv @@
module chm_front import chm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [BcW-1:0] bucket_count_i,
  input  logic           push_i,
  output logic           full_o,
  input  in_item_t       item_i,
  output logic           wr_valid_o,
  input  logic           wr_full_i,
  output work_t          wr_item_o
);

  front_state_e state_q, state_d;
  in_item_t     item_q;
  logic [31:0]  ks_q, ks_d;
  logic [BcW-1:0] rem_q, rem_d;
  logic [3:0]   cnt_q;
  logic [BcW-1:0] div_b;
  logic [BcW:0] r1, r2;
  logic         accept;

  // Clamp the modulus to 1..MaxBuckets
  always_comb begin
    if (bucket_count_i == '0) begin
      div_b = BcW'(1);
    end else if (bucket_count_i > BcW'(MaxBuckets)) begin
      div_b = BcW'(MaxBuckets);
    end else begin
      div_b = bucket_count_i;
    end
  end

  // Two restoring division steps per cycle
  always_comb begin
    r1 = {rem_q, ks_q[31]};
    if (r1 >= {1'b0, div_b}) begin
      r1 = r1 - {1'b0, div_b};
    end
    r2 = {r1[BcW-1:0], ks_q[30]};
    if (r2 >= {1'b0, div_b}) begin
      r2 = r2 - {1'b0, div_b};
    end
    rem_d = r2[BcW-1:0];
    ks_d  = {ks_q[29:0], 2'b00};
  end

  assign accept = push_i && (state_q == FR_IDLE);
  assign full_o = (state_q != FR_IDLE);

  always_comb begin
    state_d = state_q;
    wr_valid_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (push_i) begin
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        if (cnt_q == 4'd15) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        wr_valid_o = 1'b1;
        if (!wr_full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == FR_DIV) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // Hold the item and run the remainder
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      ks_q   <= item_i.key;
      rem_q  <= '0;
    end else if (state_q == FR_DIV) begin
      ks_q  <= ks_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    wr_item_o.command  = item_q.command;
    wr_item_o.key      = item_q.key;
    wr_item_o.data     = item_q.entry_data[DataBits-1:0];
    wr_item_o.bucket   = rem_q[BktW-1:0];
    wr_item_o.reserved = (item_q.key == 32'd0);
  end

endmodule

@@ hw/rtl/chm_fifo.sv @@
module chm_fifo import chm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  full_o,
  input  work_t wr_item_i,
  input  logic  rd_pop_i,
  output logic  empty_o,
  output work_t rd_item_o
);

  work_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_pop_i && !empty_o;
  assign rd_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= !wptr_q;
      end
      if (do_rd) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

@@ hw/rtl/chm_back.sv @@
module chm_back import chm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rd_empty_i,
  input  work_t     rd_item_i,
  output logic      rd_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t res_o
);

  // Storage
  logic [LinkW-1:0]    heads_mem [MaxBuckets];
  logic [31:0]         keys_mem  [PoolNodes];
  logic [DataBits-1:0] vals_mem  [PoolNodes];
  logic [LinkW-1:0]    links_mem [PoolNodes];
  logic [NodeW-1:0]    stack_mem [PoolNodes];
  logic [MaxBuckets-1:0] head_vld_q;

  back_state_e state_q, state_d;
  work_t       wk_q, wk_d;
  logic [LinkW-1:0] cur_q, cur_d, prev_q, prev_d, headv_q, headv_d;
  logic [CntW-1:0]  steps_q, steps_d, top_q, top_d, low_q, low_d, total_q, total_d;
  out_item_t   res_q, res_d;
  logic        res_valid_q, res_valid_d;

  // Registered read data
  logic [LinkW-1:0]    head_rd_q;
  logic                hvld_rd_q;
  logic [31:0]         key_rd_q;
  logic [DataBits-1:0] val_rd_q;
  logic [LinkW-1:0]    link_rd_q;
  logic [NodeW-1:0]    stk_rd_q;

  logic [NodeW-1:0] node_raddr, stk_raddr, fresh;
  logic [LinkW-1:0] hv;
  logic [CntW-1:0]  top_m1;

  // Write controls
  logic             hd_we;
  logic [LinkW-1:0] hd_wdata;
  logic             lk_we;
  logic [NodeW-1:0] lk_waddr;
  logic [LinkW-1:0] lk_wdata;
  logic             nd_we;
  logic             stk_we;

  assign hv        = hvld_rd_q ? head_rd_q : NoNode;
  assign top_m1    = top_q - CntW'(1);
  assign stk_raddr = top_m1[NodeW-1:0];
  assign fresh     = (top_m1 < low_q) ? top_m1[NodeW-1:0] : stk_rd_q;
  assign empty     = !res_valid_q;
  assign res_o     = res_q;

  always_comb begin
    node_raddr = link_rd_q[NodeW-1:0];
    if (state_q == BK_HEAD) begin
      node_raddr = hv[NodeW-1:0];
    end
  end

  // Sequencer: walk the chain, then act on hit or miss
  always_comb begin
    state_d = state_q;
    wk_d = wk_q;
    cur_d = cur_q;
    prev_d = prev_q;
    headv_d = headv_q;
    steps_d = steps_q;
    top_d = top_q;
    low_d = low_q;
    total_d = total_q;
    res_d = res_q;
    res_valid_d = res_valid_q;
    rd_pop_o = 1'b0;
    hd_we = 1'b0;
    hd_wdata = link_rd_q;
    lk_we = 1'b0;
    lk_waddr = prev_q[NodeW-1:0];
    lk_wdata = link_rd_q;
    nd_we = 1'b0;
    stk_we = 1'b0;

    if (pop && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (!rd_empty_i && !res_valid_q) begin
          rd_pop_o = 1'b1;
          wk_d = rd_item_i;
          if (rd_item_i.reserved) begin
            res_d.status = ST_RESERVED;
            res_d.found_data = '0;
            res_d.entry_count = total_q;
            res_valid_d = 1'b1;
          end else begin
            state_d = BK_HEAD_RD;
          end
        end
      end
      BK_HEAD_RD: begin
        state_d = BK_HEAD;
      end
      BK_HEAD: begin
        headv_d = hv;
        prev_d = NoNode;
        cur_d = hv;
        steps_d = '0;
        if (hv == NoNode) begin
          // Empty chain: miss
          res_d.found_data = '0;
          res_d.entry_count = total_q;
          if (wk_q.command == CMD_INSERT) begin
            if (top_q == '0) begin
              res_d.status = ST_FULL;
              res_valid_d = 1'b1;
              state_d = BK_IDLE;
            end else begin
              state_d = BK_ALLOC;
            end
          end else begin
            res_d.status = ST_ABSENT;
            res_valid_d = 1'b1;
            state_d = BK_IDLE;
          end
        end else begin
          state_d = BK_WALK;
        end
      end
      BK_WALK: begin
        res_d.found_data = '0;
        res_d.entry_count = total_q;
        if (key_rd_q == wk_q.key) begin
          res_valid_d = 1'b1;
          state_d = BK_IDLE;
          if (wk_q.command == CMD_INSERT) begin
            res_d.status = ST_DUP;
          end else if (wk_q.command == CMD_REMOVE) begin
            // Unlink the node and return it to the free stack
            res_d.status = ST_OK;
            if (prev_q == NoNode) begin
              hd_we = 1'b1;
            end else begin
              lk_we = 1'b1;
            end
            if (top_q < CntW'(PoolNodes)) begin
              stk_we = 1'b1;
              top_d = top_q + CntW'(1);
            end
            if (total_q != '0) begin
              total_d = total_q - CntW'(1);
            end
            res_d.entry_count = total_d;
          end else begin
            res_d.status = ST_OK;
            res_d.found_data = 64'(val_rd_q);
          end
        end else begin
          prev_d = cur_q;
          cur_d = link_rd_q;
          steps_d = steps_q + CntW'(1);
          if (link_rd_q[NodeW] || (steps_d == CntW'(PoolNodes))) begin
            // End of chain: miss
            if (wk_q.command == CMD_INSERT) begin
              if (top_q == '0) begin
                res_d.status = ST_FULL;
                res_valid_d = 1'b1;
                state_d = BK_IDLE;
              end else begin
                state_d = BK_ALLOC;
              end
            end else begin
              res_d.status = ST_ABSENT;
              res_valid_d = 1'b1;
              state_d = BK_IDLE;
            end
          end
        end
      end
      BK_ALLOC: begin
        state_d = BK_INSERT;
      end
      BK_INSERT: begin
        // Link a fresh node in at the chain head
        nd_we = 1'b1;
        lk_we = 1'b1;
        lk_waddr = fresh;
        lk_wdata = headv_q;
        hd_we = 1'b1;
        hd_wdata = {1'b0, fresh};
        top_d = top_m1;
        if (top_m1 < low_q) begin
          low_d = top_m1;
        end
        total_d = total_q + CntW'(1);
        res_d.status = ST_OK;
        res_d.found_data = '0;
        res_d.entry_count = total_d;
        res_valid_d = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      top_q       <= CntW'(PoolNodes);
      low_q       <= CntW'(PoolNodes);
      total_q     <= '0;
      res_valid_q <= 1'b0;
      head_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      low_q       <= low_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
      if (hd_we) begin
        head_vld_q[wk_q.bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q    <= wk_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    headv_q <= headv_d;
    steps_q <= steps_d;
    res_q   <= res_d;
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    head_rd_q <= heads_mem[wk_q.bucket];
    hvld_rd_q <= head_vld_q[wk_q.bucket];
    if (hd_we) begin
      heads_mem[wk_q.bucket] <= hd_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= keys_mem[node_raddr];
    val_rd_q  <= vals_mem[node_raddr];
    if (nd_we) begin
      keys_mem[fresh] <= wk_q.key;
      vals_mem[fresh] <= wk_q.data;
    end
  end

  always_ff @(posedge clk_i) begin
    link_rd_q <= links_mem[node_raddr];
    if (lk_we) begin
      links_mem[lk_waddr] <= lk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    stk_rd_q <= stack_mem[stk_raddr];
    if (stk_we) begin
      stack_mem[top_q[NodeW-1:0]] <= cur_q[NodeW-1:0];
    end
  end

endmodule

@@ hw/rtl/chained_hash_map_top.sv @@
// Channel   Direction  Handshake              Payload
// input     in         push / full            in_item_i (command, key, entry_data)
// result    out        empty / pop            out_item_o (status, found_data, entry_count)
// config    in         cfg_we_i               cfg_wdata_i (bucket_count)
//
// The front takes one item at a time and works out the bucket remainder two
// bits per cycle, then hands it to a two-entry queue. The back reads the
// bucket head, then visits the chain one node at a time; a reserved key is
// answered from idle; an insert also passes through BK_ALLOC and BK_INSERT.
// Reset is immediate: bucket heads carry valid bits, the free stack a low mark.
// The back holds off a new item while a result waits to be popped.
module chained_hash_map_top import chm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  in_item_t       in_item_i,
  output logic           empty,
  input  logic           pop,
  output out_item_t      out_item_o,
  input  logic           cfg_we_i,
  input  logic [BcW-1:0] cfg_wdata_i
);

  logic [BcW-1:0] bucket_count_q;
  logic  wr_valid, wr_full, rd_pop, rd_empty;
  work_t wr_item, rd_item;

  // Bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BcReset;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  chm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .push_i         (push),
    .full_o         (full),
    .item_i         (in_item_i),
    .wr_valid_o     (wr_valid),
    .wr_full_i      (wr_full),
    .wr_item_o      (wr_item)
  );

  chm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .full_o     (wr_full),
    .wr_item_i  (wr_item),
    .rd_pop_i   (rd_pop),
    .empty_o    (rd_empty),
    .rd_item_o  (rd_item)
  );

  chm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_empty_i (rd_empty),
    .rd_item_i  (rd_item),
    .rd_pop_o   (rd_pop),
    .empty      (empty),
    .pop        (pop),
    .res_o      (out_item_o)
  );

endmodule
